FILE: rtl/svrd_pkg.sv
// svrd_pkg: shared constants, types and build-time tables for the sine voice.
// Used by svrd_ctrl, svrd_dp and sine_voice_with_release_decay. No dependencies.
package svrd_pkg;

    localparam int SAMPLE_RATE    = 48000;
    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS    = 16;

    localparam int SINE_N  = 1 << SINE_ADDR_BITS;
    localparam int NOTE_N  = 128;
    localparam int OP_W    = 2;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int GAIN_W  = 16;
    localparam int DECAY_W = 15;
    localparam int MAG_W   = SAMPLE_BITS - 1;
    localparam int Q_FRAC  = 15;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // shared multiplier
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;

    // velocity*gain/127 by reciprocal: floor(x * RECIP / 2^30), one correction step
    localparam int X_W          = 23;
    localparam int QUO_W        = 17;
    localparam int DIV_SHIFT    = 30;
    localparam int DIVISOR      = 127;
    localparam int DIVISOR_LOG  = 7;
    localparam int DIV_BIAS     = 63;
    localparam logic [MUL_W-1:0] DIV_RECIP = MUL_W'(8454660);

    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(32768);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (Q_FRAC - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD = 2'd2;

    localparam logic [GAIN_W-1:0]  VGAIN_RST = GAIN_W'(4915);
    localparam logic [DECAY_W-1:0] DECAY_RST = DECAY_W'(32440);
    localparam logic [GAIN_W-1:0]  THR_RST   = GAIN_W'(164);

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [MAG_W-1:0]      sine_mag_t;
    typedef sine_mag_t sine_rom_t [SINE_N];
    typedef phase_t    note_rom_t [NOTE_N];

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_STOP,
        CMD_VEL_MUL,
        CMD_DIV_MUL,
        CMD_START_FIX,
        CMD_AMP_MUL,
        CMD_RND1,
        CMD_REL_MUL,
        CMD_RND2,
        CMD_DECAY_MUL,
        CMD_FINISH
    } cmd_e;

    typedef struct packed {
        logic load;
        cmd_e op;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            silent;
        logic            releasing;
        logic            out_busy;
    } stat_t;

    localparam longint unsigned Q30_ONE   = 64'd1 << 30;
    localparam longint unsigned PI_Q30    = 64'd3373259426;
    localparam longint unsigned SINE_FULL = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    localparam int unsigned OCTAVE4_Q16 [12] = '{
        17145893, 18165441, 19245614, 20390018, 21602472, 22887021,
        24247954, 25689813, 27217409, 28835840, 30550508, 32367136
    };

    function automatic longint unsigned sin_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned h;
        x2 = (x * x) >> 30;
        h  = Q30_ONE - x2 / 110;
        h  = Q30_ONE - ((x2 * h) >> 30) / 72;
        h  = Q30_ONE - ((x2 * h) >> 30) / 42;
        h  = Q30_ONE - ((x2 * h) >> 30) / 20;
        h  = Q30_ONE - ((x2 * h) >> 30) / 6;
        return (x * h) >> 30;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned s;
        for (int i = 0; i < SINE_N; i++)
        begin
            x = (longint'(2 * i + 1) * PI_Q30) / (4 * SINE_N);
            s = sin_q30(x);
            if (s > Q30_ONE)
            begin
                s = Q30_ONE;
            end
            rom[i] = MAG_W'((s * SINE_FULL + (Q30_ONE >> 1)) >> 30);
        end
        return rom;
    endfunction

    function automatic phase_t note_step(int n);
        longint unsigned v;
        longint unsigned q;
        longint unsigned r;
        int              e;
        v = longint'(OCTAVE4_Q16[n % 12]);
        e = n / 12 + PHASE_BITS - 20;
        if (e >= 0)
        begin
            q = v / SAMPLE_RATE;
            r = v % SAMPLE_RATE;
            for (int i = 0; i < e; i++)
            begin
                q = q << 1;
                r = r << 1;
                if (r >= SAMPLE_RATE)
                begin
                    r = r - SAMPLE_RATE;
                    q = q | 64'd1;
                end
            end
        end
        else
        begin
            q = (v >> (-e)) / SAMPLE_RATE;
        end
        return phase_t'((q + 64'd1) >> 1);
    endfunction

    function automatic note_rom_t build_note_rom();
        note_rom_t rom;
        for (int n = 0; n < NOTE_N; n++)
        begin
            rom[n] = note_step(n);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();
    localparam note_rom_t NOTE_ROM = build_note_rom();

endpackage

FILE: rtl/sine_voice_with_release_decay.sv
// sine_voice_with_release_decay: top level of one synthesizer voice.
// Depends on svrd_pkg, svrd_ctrl and svrd_dp.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    op, note, velocity, allow_tail_off
//   out      source     out_valid/out_ready  sample, voice_active
//   cfg      sink       cfg_we (no wait)     cfg_index, cfg_data
//
// Tick: dispatch, amplitude multiply, round, then finish writes the output word;
// a release adds multiply, round and decay steps; a silent tick writes no word.
// One shared 24x24 multiplier and the registered sine ROM read set the tick length.
// Reset (rst_n, async, active low) clears the voice to silent with default config.
// A waiting output word does not block the next input; a tick holds in its last
// step only while the previous output word is still untaken.
module sine_voice_with_release_decay (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [svrd_pkg::OP_W-1:0]               op,
    input  logic [svrd_pkg::NOTE_W-1:0]             note,
    input  logic [svrd_pkg::VEL_W-1:0]              velocity,
    input  logic                                    allow_tail_off,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [svrd_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    voice_active,
    input  logic                                    cfg_we,
    input  logic [svrd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [svrd_pkg::CFG_DATA_W-1:0]         cfg_data
);

    svrd_pkg::cmd_t  cmd;
    svrd_pkg::stat_t stat;

    svrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    svrd_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op             (op),
        .note           (note),
        .velocity       (velocity),
        .allow_tail_off (allow_tail_off),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample         (sample),
        .voice_active   (voice_active),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

endmodule

FILE: rtl/svrd_ctrl.sv
// svrd_ctrl: sine voice sequencer; one datapath command per cycle unless stalled.
// Depends on svrd_pkg (cmd_t, stat_t, op codes).
module svrd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  svrd_pkg::stat_t stat,
    output svrd_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_VEL_MUL,
        ST_DIV_MUL,
        ST_START_FIX,
        ST_AMP_MUL,
        ST_RND1,
        ST_REL_MUL,
        ST_RND2,
        ST_DECAY_MUL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = svrd_pkg::CMD_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_IDLE;
                unique case (stat.op)
                    svrd_pkg::OP_START: state_next = ST_VEL_MUL;
                    svrd_pkg::OP_STOP:  cmd.op = svrd_pkg::CMD_STOP;
                    svrd_pkg::OP_TICK:
                    begin
                        if (!stat.silent)
                        begin
                            state_next = ST_AMP_MUL;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_VEL_MUL:
            begin
                cmd.op     = svrd_pkg::CMD_VEL_MUL;
                state_next = ST_DIV_MUL;
            end
            ST_DIV_MUL:
            begin
                cmd.op     = svrd_pkg::CMD_DIV_MUL;
                state_next = ST_START_FIX;
            end
            ST_START_FIX:
            begin
                cmd.op     = svrd_pkg::CMD_START_FIX;
                state_next = ST_IDLE;
            end
            ST_AMP_MUL:
            begin
                cmd.op     = svrd_pkg::CMD_AMP_MUL;
                state_next = ST_RND1;
            end
            ST_RND1:
            begin
                cmd.op     = svrd_pkg::CMD_RND1;
                state_next = stat.releasing ? ST_REL_MUL : ST_FINISH;
            end
            ST_REL_MUL:
            begin
                cmd.op     = svrd_pkg::CMD_REL_MUL;
                state_next = ST_RND2;
            end
            ST_RND2:
            begin
                cmd.op     = svrd_pkg::CMD_RND2;
                state_next = ST_DECAY_MUL;
            end
            ST_DECAY_MUL:
            begin
                cmd.op     = svrd_pkg::CMD_DECAY_MUL;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output word slot is free
                if (!stat.out_busy)
                begin
                    cmd.op     = svrd_pkg::CMD_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

FILE: rtl/svrd_dp.sv
// svrd_dp: voice datapath - config registers, phase accumulator, sine ROM,
// shared multiplier, release gain and output word register. Depends on svrd_pkg.
module svrd_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  svrd_pkg::cmd_t                       cmd,
    output svrd_pkg::stat_t                      stat,
    input  logic [svrd_pkg::OP_W-1:0]            op,
    input  logic [svrd_pkg::NOTE_W-1:0]          note,
    input  logic [svrd_pkg::VEL_W-1:0]           velocity,
    input  logic                                 allow_tail_off,
    input  logic                                 cfg_we,
    input  logic [svrd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [svrd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [svrd_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                 voice_active,
    output logic                                 out_valid,
    input  logic                                 out_ready
);

    localparam int PB = svrd_pkg::PHASE_BITS;
    localparam int AB = svrd_pkg::SINE_ADDR_BITS;
    localparam int SB = svrd_pkg::SAMPLE_BITS;

    logic [svrd_pkg::GAIN_W-1:0]  vgain_reg;
    logic [svrd_pkg::DECAY_W-1:0] decay_reg;
    logic [svrd_pkg::GAIN_W-1:0]  thr_reg;

    logic [svrd_pkg::OP_W-1:0]    op_reg;
    logic [svrd_pkg::NOTE_W-1:0]  note_reg;
    logic [svrd_pkg::VEL_W-1:0]   vel_reg;
    logic                         tail_reg;

    logic [PB-1:0]                phase_reg;
    logic [PB-1:0]                step_reg;
    logic [svrd_pkg::GAIN_W-1:0]  amp_reg;
    logic [svrd_pkg::GAIN_W-1:0]  rg_reg;
    logic                         out_valid_reg;

    logic [svrd_pkg::MAG_W-1:0]   sine_q_reg;
    logic [svrd_pkg::PROD_W-1:0]  prod_reg;
    logic [svrd_pkg::MAG_W-1:0]   mag_reg;
    logic [svrd_pkg::X_W-1:0]     x_reg;
    logic [SB-1:0]                sample_reg;
    logic                         active_reg;

    logic [AB-1:0]                sine_addr;
    logic [svrd_pkg::MUL_W-1:0]   mul_a;
    logic [svrd_pkg::MUL_W-1:0]   mul_b;
    logic                         mul_en;
    logic [svrd_pkg::PROD_W-1:0]  rnd_sum;
    logic [svrd_pkg::MAG_W-1:0]   mag_rnd;
    logic [svrd_pkg::X_W-1:0]     x_sum;
    logic [svrd_pkg::QUO_W-1:0]   q_est;
    logic [svrd_pkg::X_W:0]       q_x127;
    logic [svrd_pkg::X_W:0]       rem;
    logic [svrd_pkg::QUO_W-1:0]   q_fix;
    logic [svrd_pkg::GAIN_W-1:0]  amp_new;
    logic [svrd_pkg::GAIN_W-1:0]  rg_dec;
    logic                         releasing;
    logic [PB-1:0]                step_fin;
    logic [SB-1:0]                mag_ext;

    // quadrants 1 and 3 read the table mirrored
    assign sine_addr = phase_reg[PB-3 -: AB] ^ {AB{phase_reg[PB-2]}};

    assign releasing = (rg_reg != '0);

    // product register holds between multiplies, so a stalled finish keeps it
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        unique case (cmd.op)
            svrd_pkg::CMD_VEL_MUL:
            begin
                mul_a  = svrd_pkg::MUL_W'(vel_reg);
                mul_b  = svrd_pkg::MUL_W'(vgain_reg);
                mul_en = 1'b1;
            end
            svrd_pkg::CMD_DIV_MUL:
            begin
                mul_a  = svrd_pkg::MUL_W'(x_sum);
                mul_b  = svrd_pkg::DIV_RECIP;
                mul_en = 1'b1;
            end
            svrd_pkg::CMD_AMP_MUL:
            begin
                mul_a  = svrd_pkg::MUL_W'(sine_q_reg);
                mul_b  = svrd_pkg::MUL_W'(amp_reg);
                mul_en = 1'b1;
            end
            svrd_pkg::CMD_REL_MUL:
            begin
                mul_a  = svrd_pkg::MUL_W'(mag_reg);
                mul_b  = svrd_pkg::MUL_W'(rg_reg);
                mul_en = 1'b1;
            end
            svrd_pkg::CMD_DECAY_MUL:
            begin
                mul_a  = svrd_pkg::MUL_W'(rg_reg);
                mul_b  = svrd_pkg::MUL_W'(decay_reg);
                mul_en = 1'b1;
            end
            default:
            begin
                mul_a  = '0;
                mul_b  = '0;
                mul_en = 1'b0;
            end
        endcase
    end

    assign rnd_sum = prod_reg + svrd_pkg::ROUND_HALF;
    assign mag_rnd = rnd_sum[svrd_pkg::Q_FRAC +: svrd_pkg::MAG_W];

    // start: amplitude = min(1.0, round(velocity * gain / 127))
    assign x_sum  = prod_reg[svrd_pkg::X_W-1:0] + svrd_pkg::X_W'(svrd_pkg::DIV_BIAS);
    assign q_est  = prod_reg[svrd_pkg::DIV_SHIFT +: svrd_pkg::QUO_W];
    assign q_x127 = ((svrd_pkg::X_W+1)'(q_est) << svrd_pkg::DIVISOR_LOG)
                    - (svrd_pkg::X_W+1)'(q_est);
    assign rem    = {1'b0, x_reg} - q_x127;
    assign q_fix  = (rem >= (svrd_pkg::X_W+1)'(svrd_pkg::DIVISOR)) ? q_est + 1'b1 : q_est;
    assign amp_new = (q_fix > {1'b0, svrd_pkg::GAIN_ONE}) ? svrd_pkg::GAIN_ONE
                                                          : q_fix[svrd_pkg::GAIN_W-1:0];

    // release: truncating decay, stop at or below threshold
    assign rg_dec   = prod_reg[svrd_pkg::Q_FRAC +: svrd_pkg::GAIN_W];
    assign step_fin = (releasing && (rg_dec <= thr_reg)) ? '0 : step_reg;
    assign mag_ext  = SB'(mag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vgain_reg <= svrd_pkg::VGAIN_RST;
            decay_reg <= svrd_pkg::DECAY_RST;
            thr_reg   <= svrd_pkg::THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                svrd_pkg::CFG_VELOCITY_GAIN:  vgain_reg <= cfg_data;
                svrd_pkg::CFG_DECAY_FACTOR:   decay_reg <= cfg_data[svrd_pkg::DECAY_W-1:0];
                svrd_pkg::CFG_STOP_THRESHOLD: thr_reg   <= cfg_data;
                default:                      thr_reg   <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            step_reg      <= '0;
            amp_reg       <= '0;
            rg_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                svrd_pkg::CMD_STOP:
                begin
                    if (tail_reg)
                    begin
                        if (!releasing)
                        begin
                            rg_reg <= svrd_pkg::GAIN_ONE;
                        end
                    end
                    else
                    begin
                        step_reg <= '0;
                    end
                end
                svrd_pkg::CMD_START_FIX:
                begin
                    phase_reg <= '0;
                    rg_reg    <= '0;
                    amp_reg   <= amp_new;
                    step_reg  <= svrd_pkg::NOTE_ROM[note_reg];
                end
                svrd_pkg::CMD_FINISH:
                begin
                    phase_reg     <= phase_reg + step_reg;
                    out_valid_reg <= 1'b1;
                    if (releasing)
                    begin
                        rg_reg   <= rg_dec;
                        step_reg <= step_fin;
                    end
                end
                default:
                begin
                    phase_reg <= phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            note_reg <= note;
            vel_reg  <= velocity;
            tail_reg <= allow_tail_off;
        end
        sine_q_reg <= svrd_pkg::SINE_ROM[sine_addr];
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.op == svrd_pkg::CMD_DIV_MUL)
        begin
            x_reg <= x_sum;
        end
        if ((cmd.op == svrd_pkg::CMD_RND1) || (cmd.op == svrd_pkg::CMD_RND2))
        begin
            mag_reg <= mag_rnd;
        end
        if (cmd.op == svrd_pkg::CMD_FINISH)
        begin
            sample_reg <= phase_reg[PB-1] ? (SB'(0) - mag_ext) : mag_ext;
            active_reg <= (step_fin != '0);
        end
    end

    assign stat.op        = op_reg;
    assign stat.silent    = (step_reg == '0);
    assign stat.releasing = releasing;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign sample       = sample_reg;
    assign voice_active = active_reg;
    assign out_valid    = out_valid_reg;

`ifndef ASSERT_OFF
    a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
        amp_reg <= svrd_pkg::GAIN_ONE)
        else $error("amplitude above unity");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        rg_reg <= svrd_pkg::GAIN_ONE)
        else $error("release gain above unity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.op == svrd_pkg::CMD_FINISH && out_valid_reg && !out_ready))
        else $error("output word overwritten before taken");

    a_active_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == svrd_pkg::CMD_FINISH) |=> (out_valid_reg && (active_reg == (step_reg != '0))))
        else $error("voice_active disagrees with phase step");
`endif

endmodule
